>>> hdl/esc_slew_duty_generator_core_macros.svh
// Assertion macros for the slew/duty generator core.
// Each expects clk and arst_n in the scope where it is used.
`ifndef ESC_SLEW_DUTY_GENERATOR_CORE_MACROS_SVH
`define ESC_SLEW_DUTY_GENERATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ESD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ESD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ESD_ASSERT_IMPL(lbl, ante, cons)
`define ESD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/esd_pkg.sv
package esd_pkg;

	localparam int CHANNELS   = 4;
	localparam int CH_W       = 2;
	localparam int LEVEL_W    = 8;
	localparam int RATE_W     = 8;
	localparam int SCALE_W    = 4;
	localparam int PRESC_W    = 16;
	localparam int DUTY_W     = 16;
	localparam int PROD_W     = 2 * LEVEL_W;
	localparam int BASE_W     = 13;
	localparam int DUTY_FULL_W = BASE_W + SCALE_W;
	localparam int CFG_IDX_W  = 1;
	localparam int RAMP_LEN   = 4;
	localparam int RATE_CODES = 8;

	localparam int JOBQ_DEPTH = 2;
	localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
	localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

	localparam int POWER_SHIFT = 4;
	localparam logic [LEVEL_W-1:0] REFRESH_NUM      = 8'd25;
	localparam logic [BASE_W-1:0]  MIN_DUTY         = 13'd400;
	localparam logic [PRESC_W-1:0] INVALID_PRESCALE = 16'hFFFF;
	localparam logic [PRESC_W-1:0] RESET_PRESCALE   = 16'd210;
	localparam logic [SCALE_W-1:0] RESET_SCALER     = 4'd1;
	localparam logic [RATE_W-1:0]  RESET_RATE       = 8'd1;
	localparam logic [LEVEL_W-1:0] RESET_SENS       = 8'd25;

	// request codes
	localparam logic [1:0] REQ_SET_TARGET = 2'd0;
	localparam logic [1:0] REQ_RAMP_TICK  = 2'd1;
	localparam logic [1:0] REQ_REFRESH    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UPDATE_RATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_SENS = 1'b1;

	// ramp visit order: left, rear, front, right
	localparam logic [CH_W-1:0] RAMP_ORDER [RAMP_LEN] = '{2'd1, 2'd3, 2'd0, 2'd2};

	function automatic logic [PRESC_W-1:0] rate_prescale(input logic [2:0] idx);
		logic [PRESC_W-1:0] p;
		unique case (idx)
			3'd0: p = 16'd210;
			3'd1: p = 16'd105;
			3'd2: p = 16'd70;
			3'd3: p = 16'd52;
			3'd4: p = 16'd42;
			3'd5: p = 16'd35;
			3'd6: p = 16'd29;
			3'd7: p = 16'd26;
		endcase
		return p;
	endfunction

	// one compare job handed from front to back
	typedef struct packed {
		logic [CH_W-1:0]    ch;
		logic [LEVEL_W-1:0] num;
		logic [LEVEL_W-1:0] power;
		logic [SCALE_W-1:0] scaler;
		logic [PRESC_W-1:0] prescale;
		logic               last;
	} job_t;

endpackage

>>> hdl/esc_slew_duty_generator_core.sv
// Four-channel ESC slew limiter and PWM compare generator. A set-target word
// stores a channel's target power. A ramp tick walks the four ramp slots
// (left, rear, front, right), one slot per cycle while the job queue has room,
// and holds full high until the last moving channel is done, so the walk can
// end early; each moving channel steps its power by one and yields a compare
// word. A refresh word reloads prescaler and scaler from update_rate (a bad
// code pins the prescaler to all ones and keeps the scaler) and walks front,
// left, right, rear, yielding four compare words. The front end takes no new
// word until its channel walk is done and stalls while the job queue is full.
// The back end is a two-stage multiply pipeline (power * numerator, then
// (p/16 + 400) * scaler) at one word per cycle while results are popped; each
// result waits on the result ports until popped. Configuration writes are
// registered; a new update rate reaches the scaler and prescaler only at the
// next refresh.
module esc_slew_duty_generator_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// input queue side
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      req_type,
	input  logic [esd_pkg::CH_W-1:0]        motor_sel,
	input  logic [esd_pkg::LEVEL_W-1:0]     target_level,
	// result queue side
	output logic                            empty,
	input  logic                            pop,
	output logic [esd_pkg::CH_W-1:0]        out_channel,
	output logic [esd_pkg::DUTY_W-1:0]      compare_value,
	output logic [esd_pkg::PRESC_W-1:0]     prescaler,
	output logic                            last,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [esd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [esd_pkg::RATE_W-1:0]      cfg_data
);

	// front to queue
	logic          job_push;
	esd_pkg::job_t job_in;
	logic          jobq_full;

	// queue to back
	esd_pkg::job_t job_out;
	logic          jobq_empty;
	logic          jobq_pop;

	// front: decodes words, owns targets, powers and rate state,
	// walks the channels and emits one job per result word
	esd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.motor_sel    (motor_sel),
		.target_level (target_level),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.jobq_full    (jobq_full),
		.job_push     (job_push),
		.job          (job_in)
	);

	// short job queue so front and back stall independently
	esd_job_fifo u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (jobq_full),
		.pop    (jobq_pop),
		.dout   (job_out),
		.empty  (jobq_empty)
	);

	// back: compare arithmetic and the result output register
	esd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (job_out),
		.jobq_empty    (jobq_empty),
		.jobq_pop      (jobq_pop),
		.empty         (empty),
		.pop           (pop),
		.out_channel   (out_channel),
		.compare_value (compare_value),
		.prescaler     (prescaler),
		.last          (last)
	);

endmodule

>>> hdl/esd_front.sv
`include "esc_slew_duty_generator_core_macros.svh"

module esd_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [1:0]                       req_type,
	input  logic [esd_pkg::CH_W-1:0]         motor_sel,
	input  logic [esd_pkg::LEVEL_W-1:0]      target_level,
	input  logic                             cfg_we,
	input  logic [esd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [esd_pkg::RATE_W-1:0]       cfg_data,
	input  logic                             jobq_full,
	output logic                             job_push,
	output esd_pkg::job_t                    job
);

	typedef enum logic [1:0] {F_IDLE, F_RAMP, F_REFRESH} fstate_t;

	localparam logic [esd_pkg::CH_W-1:0] LAST_CH = esd_pkg::CH_W'(esd_pkg::CHANNELS - 1);

	fstate_t                             state_q;
	logic [esd_pkg::CH_W-1:0]            idx_q;
	logic [esd_pkg::RAMP_LEN-1:0]        mask_q;
	logic [esd_pkg::RATE_W-1:0]          update_rate_q;
	logic [esd_pkg::LEVEL_W-1:0]         sens_q;
	logic [esd_pkg::LEVEL_W-1:0]         tgt_q [esd_pkg::CHANNELS];
	logic [esd_pkg::LEVEL_W-1:0]         cur_q [esd_pkg::CHANNELS];
	logic [esd_pkg::SCALE_W-1:0]         scaler_q;
	logic [esd_pkg::PRESC_W-1:0]         prescale_q;

	logic                                accept;
	logic [esd_pkg::RAMP_LEN-1:0]        tick_mask;
	logic [esd_pkg::CH_W-1:0]            ramp_ch;
	logic                                ramp_active;
	logic [esd_pkg::LEVEL_W-1:0]         new_power;
	logic [esd_pkg::RAMP_LEN-1:0]        mask_next;
	logic                                rate_ok;
	logic [2:0]                          rate_idx;

	assign full   = (state_q != F_IDLE);
	assign accept = push && (state_q == F_IDLE);

	// channels that will move on this tick; each moves on its own, so the
	// mask taken at accept stays exact for the whole walk
	always_comb begin
		tick_mask = '0;
		for (int c = 0; c < esd_pkg::CHANNELS; c++) begin
			tick_mask[c] = (tgt_q[c] != cur_q[c]);
		end
	end

	assign ramp_ch     = esd_pkg::RAMP_ORDER[idx_q];
	assign ramp_active = mask_q[ramp_ch];
	assign new_power   = (tgt_q[ramp_ch] > cur_q[ramp_ch]) ? cur_q[ramp_ch] + 8'd1
	                                                       : cur_q[ramp_ch] - 8'd1;
	assign mask_next   = mask_q & ~(esd_pkg::RAMP_LEN'(1) << ramp_ch);

	assign rate_ok  = (update_rate_q != '0) &&
	                  (update_rate_q <= esd_pkg::RATE_W'(esd_pkg::RATE_CODES));
	assign rate_idx = 3'(update_rate_q - 8'd1);

	always_comb begin
		job_push = 1'b0;
		job      = '0;
		unique case (state_q)
			F_RAMP: begin
				job_push     = ramp_active && !jobq_full;
				job.ch       = ramp_ch;
				job.num      = sens_q;
				job.power    = new_power;
				job.scaler   = scaler_q;
				job.prescale = prescale_q;
				job.last     = (mask_next == '0);
			end
			F_REFRESH: begin
				job_push     = !jobq_full;
				job.ch       = idx_q;
				job.num      = esd_pkg::REFRESH_NUM;
				job.power    = cur_q[idx_q];
				job.scaler   = scaler_q;
				job.prescale = prescale_q;
				job.last     = (idx_q == LAST_CH);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= F_IDLE;
			idx_q         <= '0;
			mask_q        <= '0;
			update_rate_q <= esd_pkg::RESET_RATE;
			sens_q        <= esd_pkg::RESET_SENS;
			scaler_q      <= esd_pkg::RESET_SCALER;
			prescale_q    <= esd_pkg::RESET_PRESCALE;
			for (int c = 0; c < esd_pkg::CHANNELS; c++) begin
				tgt_q[c] <= '0;
				cur_q[c] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					esd_pkg::REG_UPDATE_RATE:   update_rate_q <= cfg_data;
					esd_pkg::REG_THROTTLE_SENS: sens_q        <= cfg_data;
				endcase
			end
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						case (req_type)
							esd_pkg::REQ_SET_TARGET: begin
								if (int'(motor_sel) < esd_pkg::CHANNELS) begin
									tgt_q[motor_sel] <= target_level;
								end
							end
							esd_pkg::REQ_RAMP_TICK: begin
								if (tick_mask != '0) begin
									state_q <= F_RAMP;
									idx_q   <= '0;
									mask_q  <= tick_mask;
								end
							end
							esd_pkg::REQ_REFRESH: begin
								state_q <= F_REFRESH;
								idx_q   <= '0;
								if (rate_ok) begin
									scaler_q   <= esd_pkg::SCALE_W'(update_rate_q);
									prescale_q <= esd_pkg::rate_prescale(rate_idx);
								end else begin
									prescale_q <= esd_pkg::INVALID_PRESCALE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				F_RAMP: begin
					if (!ramp_active || !jobq_full) begin
						idx_q <= idx_q + 1'b1;
						if (ramp_active) begin
							cur_q[ramp_ch] <= new_power;
							mask_q         <= mask_next;
							if (mask_next == '0) begin
								state_q <= F_IDLE;
							end
						end
					end
				end
				F_REFRESH: begin
					if (!jobq_full) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == LAST_CH) begin
							state_q <= F_IDLE;
						end
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	`ESD_ASSERT_IMPL(a_push_room, job_push, !jobq_full)
	`ESD_ASSERT_IMPL(a_ramp_has_work, state_q == F_RAMP, mask_q != '0)
	`ESD_ASSERT_NEXT(a_last_ends_walk, job_push && job.last, state_q == F_IDLE)

endmodule

>>> hdl/esd_job_fifo.sv
`include "esc_slew_duty_generator_core_macros.svh"

module esd_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  esd_pkg::job_t din,
	output logic          full,
	input  logic          pop,
	output esd_pkg::job_t dout,
	output logic          empty
);

	localparam logic [esd_pkg::JOBQ_PTR_W-1:0] PTR_LAST =
		esd_pkg::JOBQ_PTR_W'(esd_pkg::JOBQ_DEPTH - 1);
	localparam logic [esd_pkg::JOBQ_CNT_W-1:0] CNT_FULL =
		esd_pkg::JOBQ_CNT_W'(esd_pkg::JOBQ_DEPTH);

	esd_pkg::job_t                     slot_q [esd_pkg::JOBQ_DEPTH];
	logic [esd_pkg::JOBQ_PTR_W-1:0]    wr_ptr_q;
	logic [esd_pkg::JOBQ_PTR_W-1:0]    rd_ptr_q;
	logic [esd_pkg::JOBQ_CNT_W-1:0]    cnt_q;
	logic                              do_push;
	logic                              do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ESD_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CNT_FULL)

endmodule

>>> hdl/esd_back.sv
`include "esc_slew_duty_generator_core_macros.svh"

module esd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  esd_pkg::job_t                 job,
	input  logic                          jobq_empty,
	output logic                          jobq_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [esd_pkg::CH_W-1:0]      out_channel,
	output logic [esd_pkg::DUTY_W-1:0]    compare_value,
	output logic [esd_pkg::PRESC_W-1:0]   prescaler,
	output logic                          last
);

	logic                              valid_s1;
	logic [esd_pkg::PROD_W-1:0]        prod_s1;
	logic [esd_pkg::CH_W-1:0]          ch_s1;
	logic [esd_pkg::SCALE_W-1:0]       scaler_s1;
	logic [esd_pkg::PRESC_W-1:0]       prescale_s1;
	logic                              last_s1;

	logic                              valid_s2;
	logic [esd_pkg::CH_W-1:0]          ch_s2;
	logic [esd_pkg::DUTY_W-1:0]        compare_s2;
	logic [esd_pkg::PRESC_W-1:0]       prescale_s2;
	logic                              last_s2;

	logic                              s1_load;
	logic                              s2_load;
	logic [esd_pkg::BASE_W-1:0]        base;
	logic [esd_pkg::DUTY_FULL_W-1:0]   duty_full;

	assign s2_load  = valid_s1 && (!valid_s2 || pop);
	assign s1_load  = !jobq_empty && (!valid_s1 || s2_load);
	assign jobq_pop = s1_load;

	// (num*power)/16 + 400, then times the rate scaler; kept to 16 bits
	assign base      = esd_pkg::BASE_W'(prod_s1 >> esd_pkg::POWER_SHIFT) + esd_pkg::MIN_DUTY;
	assign duty_full = esd_pkg::DUTY_FULL_W'(base) * esd_pkg::DUTY_FULL_W'(scaler_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_load) begin
				valid_s1 <= 1'b1;
			end else if (s2_load) begin
				valid_s1 <= 1'b0;
			end
			if (s2_load) begin
				valid_s2 <= 1'b1;
			end else if (pop) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			prod_s1     <= esd_pkg::PROD_W'(job.num) * esd_pkg::PROD_W'(job.power);
			ch_s1       <= job.ch;
			scaler_s1   <= job.scaler;
			prescale_s1 <= job.prescale;
			last_s1     <= job.last;
		end
		if (s2_load) begin
			ch_s2       <= ch_s1;
			compare_s2  <= duty_full[esd_pkg::DUTY_W-1:0];
			prescale_s2 <= prescale_s1;
			last_s2     <= last_s1;
		end
	end

	assign empty         = !valid_s2;
	assign out_channel   = ch_s2;
	assign compare_value = compare_s2;
	assign prescaler     = prescale_s2;
	assign last          = last_s2;

	`ESD_ASSERT_NEXT(a_result_holds, valid_s2 && !pop, valid_s2 && $stable(compare_s2))

endmodule

>>> tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// req_type 3 has no meaning; the block must drop it silently
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// channel numbering on motor_sel and out_channel
	localparam logic [1:0] CH_FRONT = 2'd0;
	localparam logic [1:0] CH_LEFT  = 2'd1;
	localparam logic [1:0] CH_RIGHT = 2'd2;
	localparam logic [1:0] CH_REAR  = 2'd3;

	// slew visit order on a tick
	localparam logic [1:0] SLEW_ORDER [4] = '{CH_LEFT, CH_REAR, CH_FRONT, CH_RIGHT};

	// rate code 1..8 -> timer prescaler
	localparam logic [15:0] PRESC_OF_CODE [8] =
		'{16'd210, 16'd105, 16'd70, 16'd52, 16'd42, 16'd35, 16'd29, 16'd26};
	localparam logic [15:0] PRESC_BAD_CODE = 16'hFFFF;

	localparam int DUTY_BASE   = 400;
	localparam int REFRESH_K   = 25;
	localparam int SETTLE_CYC  = 8;       // tick walk plus multiply pipe plus slack
	localparam int CYCLE_LIMIT = 500000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [1:0]  req_type = esd_pkg::REQ_SET_TARGET;
	logic [1:0]  motor_sel = CH_FRONT;
	logic [7:0]  target_level = 8'd0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  out_channel;
	logic [15:0] compare_value;
	logic [15:0] prescaler;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = esd_pkg::REG_UPDATE_RATE;
	logic [7:0]  cfg_data = 8'd0;

	esc_slew_duty_generator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.motor_sel    (motor_sel),
		.target_level (target_level),
		.empty        (empty),
		.pop          (pop),
		.out_channel  (out_channel),
		.compare_value(compare_value),
		.prescaler    (prescaler),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// one expected compare word
	typedef struct packed {
		logic [1:0]  ch;
		logic [15:0] cmp;
		logic [15:0] presc;
		logic        tail;
	} duty_word_t;

	// directed row; chk marks rows whose compare/prescaler are typed in
	typedef struct packed {
		logic [1:0]  req;
		logic [1:0]  sel;
		logic [7:0]  lvl;
		logic        chk;
		logic [15:0] cmp;
		logic [15:0] presc;
	} drill_row_t;

	localparam int DRILL_LEN = 18;
	localparam drill_row_t DRILL [DRILL_LEN] = '{
		// straight after reset: every power 0, scaler 1 -> 400 on all four
		'{esd_pkg::REQ_REFRESH,    CH_FRONT, 8'd0,   1'b1, 16'd400, 16'd210},
		// nothing to slew, then the dead request code with all bits set
		'{esd_pkg::REQ_RAMP_TICK,  CH_FRONT, 8'd0,   1'b0, 16'd0,   16'd0},
		'{REQ_UNUSED,              CH_REAR,  8'd255, 1'b0, 16'd0,   16'd0},
		// targets at both extremes, one target equal to current power
		'{esd_pkg::REQ_SET_TARGET, CH_FRONT, 8'd255, 1'b0, 16'd0,   16'd0},
		'{esd_pkg::REQ_SET_TARGET, CH_LEFT,  8'd255, 1'b0, 16'd0,   16'd0},
		'{esd_pkg::REQ_SET_TARGET, CH_RIGHT, 8'd1,   1'b0, 16'd0,   16'd0},
		'{esd_pkg::REQ_SET_TARGET, CH_REAR,  8'd0,   1'b0, 16'd0,   16'd0},
		'{esd_pkg::REQ_RAMP_TICK,  CH_FRONT, 8'd0,   1'b0, 16'd0,   16'd0},
		'{esd_pkg::REQ_RAMP_TICK,  CH_REAR,  8'd0,   1'b0, 16'd0,   16'd0},
		// reverse the left channel mid-ramp
		'{esd_pkg::REQ_SET_TARGET, CH_LEFT,  8'd0,   1'b0, 16'd0,   16'd0},
		'{esd_pkg::REQ_RAMP_TICK,  CH_FRONT, 8'd0,   1'b0, 16'd0,   16'd0},
		'{REQ_UNUSED,              CH_FRONT, 8'd0,   1'b0, 16'd0,   16'd0},
		'{esd_pkg::REQ_SET_TARGET, CH_REAR,  8'd128, 1'b0, 16'd0,   16'd0},
		'{esd_pkg::REQ_RAMP_TICK,  CH_FRONT, 8'd0,   1'b0, 16'd0,   16'd0},
		'{esd_pkg::REQ_REFRESH,    CH_LEFT,  8'd77,  1'b0, 16'd0,   16'd0},
		'{esd_pkg::REQ_SET_TARGET, CH_RIGHT, 8'd0,   1'b0, 16'd0,   16'd0},
		'{esd_pkg::REQ_RAMP_TICK,  CH_FRONT, 8'd0,   1'b0, 16'd0,   16'd0},
		'{esd_pkg::REQ_RAMP_TICK,  CH_RIGHT, 8'd3,   1'b0, 16'd0,   16'd0}
	};

	// shadow of the block: configuration and slew state
	logic [7:0]  rate_code;
	logic [7:0]  sens;
	logic [7:0]  tgt_pwr [4];
	logic [7:0]  cur_pwr [4];
	logic [3:0]  scale;
	logic [15:0] presc;

	duty_word_t  duty_due [$];   // compare words still owed by the block

	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int settings_used = 1;
	int tx_calm = 0;
	int rx_calm = 0;
	int cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// idle draw: mostly a random gap, with occasional runs of back-to-back words
	function automatic int draw_idle(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	function automatic logic [15:0] duty_of_power(input logic [7:0] num, input logic [7:0] pwr);
		int unsigned v;
		v = ((32'(num) * 32'(pwr)) / 16 + DUTY_BASE) * 32'(scale);
		return v[15:0];
	endfunction

	// advance the shadow state by one accepted word and queue the compare words it owes
	function automatic void predict_duty(input logic [1:0] req, input logic [1:0] sel,
			input logic [7:0] lvl);
		int n;
		logic [1:0] ch;
		duty_word_t w;
		n = 0;
		case (req)
			esd_pkg::REQ_SET_TARGET: tgt_pwr[sel] = lvl;
			esd_pkg::REQ_RAMP_TICK: begin
				for (int i = 0; i < 4; i++) begin
					ch = SLEW_ORDER[i];
					if (tgt_pwr[ch] != cur_pwr[ch]) begin
						if (tgt_pwr[ch] < cur_pwr[ch])
							cur_pwr[ch] = cur_pwr[ch] - 8'd1;
						else
							cur_pwr[ch] = cur_pwr[ch] + 8'd1;
						w.ch = ch;
						w.cmp = duty_of_power(sens, cur_pwr[ch]);
						w.presc = presc;
						w.tail = 1'b0;
						duty_due.push_back(w);
						n++;
					end
				end
			end
			esd_pkg::REQ_REFRESH: begin
				// bad code: prescaler pinned, scaler left alone
				if (rate_code >= 8'd1 && rate_code <= 8'd8) begin
					scale = rate_code[3:0];
					presc = PRESC_OF_CODE[rate_code - 8'd1];
				end else begin
					presc = PRESC_BAD_CODE;
				end
				for (int i = 0; i < 4; i++) begin
					w.ch = 2'(i);
					w.cmp = duty_of_power(8'(REFRESH_K), cur_pwr[i]);
					w.presc = presc;
					w.tail = 1'b0;
					duty_due.push_back(w);
					n++;
				end
			end
			default: ;
		endcase
		if (n > 0)
			duty_due[duty_due.size() - 1].tail = 1'b1;
	endfunction

	// Offer one request word after a random gap and hold it until taken.
	// push is only lowered when a gap follows, so it never toggles within a step.
	task automatic send_word(input logic [1:0] req, input logic [1:0] sel, input logic [7:0] lvl,
			input logic chk, input logic [15:0] cmp_k, input logic [15:0] presc_k);
		int gap;
		gap = draw_idle(tx_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		req_type <= req;
		motor_sel <= sel;
		target_level <= lvl;
		do @(posedge clk); while (full);
		predict_duty(req, sel, lvl);
		// typed-in rows: all four refresh words share one known value
		if (chk) begin
			for (int i = duty_due.size() - 4; i < duty_due.size(); i++) begin
				duty_due[i].cmp = cmp_k;
				duty_due[i].presc = presc_k;
			end
		end
		words_sent++;
	endtask

	// Stop sending, let every owed word drain, then give a silent tick time to finish.
	task automatic drain_all();
		push <= 1'b0;
		while (duty_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Both registers per phase, written only with the block idle.
	task automatic program_regs(input logic [7:0] rate, input logic [7:0] sensitivity);
		drain_all();
		cfg_we <= 1'b1;
		cfg_index <= esd_pkg::REG_UPDATE_RATE;
		cfg_data <= rate;
		@(posedge clk);
		cfg_index <= esd_pkg::REG_THROTTLE_SENS;
		cfg_data <= sensitivity;
		@(posedge clk);
		cfg_we <= 1'b0;
		rate_code = rate;
		sens = sensitivity;
		settings_used++;
		@(posedge clk);
	endtask

	// random traffic: mostly ticks and target moves, some refreshes, a little dead code
	task automatic random_mix(input int count);
		int r;
		logic [7:0] lvl;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_word(esd_pkg::REQ_RAMP_TICK, 2'($urandom), 8'($urandom), 1'b0,
					16'd0, 16'd0);
			end else if (r < 75) begin
				case ($urandom_range(0, 7))
					0: lvl = 8'd0;
					1: lvl = 8'd255;
					default: lvl = 8'($urandom_range(0, 255));
				endcase
				send_word(esd_pkg::REQ_SET_TARGET, 2'($urandom), lvl, 1'b0, 16'd0, 16'd0);
			end else if (r < 92) begin
				send_word(esd_pkg::REQ_REFRESH, 2'($urandom), 8'($urandom), 1'b0,
					16'd0, 16'd0);
			end else begin
				send_word(REQ_UNUSED, 2'($urandom), 8'($urandom), 1'b0, 16'd0, 16'd0);
			end
		end
	endtask

	// result side: random stall per word, compare each popped word with the oldest owed one
	initial begin : result_side
		duty_word_t want;
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_idle(rx_calm);
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (duty_due.size() == 0) begin
				$error("unexpected duty word: channel %0d compare %0d prescaler %0d",
					out_channel, compare_value, prescaler);
				errors++;
			end else begin
				want = duty_due.pop_front();
				words_checked++;
				if (out_channel !== want.ch) begin
					$error("out_channel: expected %0d, actual %0d", want.ch, out_channel);
					errors++;
				end
				if (compare_value !== want.cmp) begin
					$error("compare_value: expected %0d, actual %0d", want.cmp, compare_value);
					errors++;
				end
				if (prescaler !== want.presc) begin
					$error("prescaler: expected %0d, actual %0d", want.presc, prescaler);
					errors++;
				end
				if (last !== want.tail) begin
					$error("last: expected %0d, actual %0d", want.tail, last);
					errors++;
				end
			end
		end
	end

	// watchdog
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[esc_slew_duty_generator_core] ERROR");
		$finish;
	end

	initial begin : stimulus
		// shadow reset values
		rate_code = esd_pkg::RESET_RATE;
		sens = esd_pkg::RESET_SENS;
		scale = 4'd1;
		presc = 16'd210;
		for (int i = 0; i < 4; i++) begin
			tgt_pwr[i] = 8'd0;
			cur_pwr[i] = 8'd0;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset settings
		for (int i = 0; i < DRILL_LEN; i++)
			send_word(DRILL[i].req, DRILL[i].sel, DRILL[i].lvl, DRILL[i].chk,
				DRILL[i].cmp, DRILL[i].presc);

		// fastest rate, full sensitivity: climb every channel to full power
		// so the largest compare value shows up, refreshing along the way
		program_regs(8'd8, 8'd255);
		send_word(esd_pkg::REQ_SET_TARGET, CH_REAR, 8'd255, 1'b0, 16'd0, 16'd0);
		send_word(esd_pkg::REQ_SET_TARGET, CH_LEFT, 8'd255, 1'b0, 16'd0, 16'd0);
		send_word(esd_pkg::REQ_SET_TARGET, CH_FRONT, 8'd255, 1'b0, 16'd0, 16'd0);
		send_word(esd_pkg::REQ_SET_TARGET, CH_RIGHT, 8'd255, 1'b0, 16'd0, 16'd0);
		for (int k = 0; k < 258; k++) begin
			if (k % 64 == 63)
				send_word(esd_pkg::REQ_REFRESH, CH_FRONT, 8'd0, 1'b0, 16'd0, 16'd0);
			send_word(esd_pkg::REQ_RAMP_TICK, 2'($urandom), 8'($urandom), 1'b0,
				16'd0, 16'd0);
		end
		send_word(esd_pkg::REQ_REFRESH, CH_FRONT, 8'd0, 1'b0, 16'd0, 16'd0);

		// rate code 0 is invalid: prescaler pinned, scaler stays at 8
		program_regs(8'd0, 8'd0);
		random_mix(38);
		// all-ones rate code, also invalid
		program_regs(8'd255, 8'd1);
		random_mix(38);
		program_regs(8'd3, 8'($urandom));
		random_mix(38);
		program_regs(($urandom_range(0, 1) == 1) ? 8'($urandom_range(1, 8)) : 8'($urandom),
			8'($urandom));
		random_mix(38);
		// back to the reset settings
		program_regs(esd_pkg::RESET_RATE, esd_pkg::RESET_SENS);
		random_mix(38);

		drain_all();
		repeat (20) @(posedge clk);

		$display("sent %0d request words, checked %0d duty words across %0d register settings",
			words_sent, words_checked, settings_used);
		if (errors == 0) begin
			$display("[esc_slew_duty_generator_core] OK");
		end else begin
			$display("[esc_slew_duty_generator_core] ERROR");
		end
		$finish;
	end

endmodule
